FILE: hw/rtl/bmff_pkg.sv
// Shared types and constants of the box scanner.
`timescale 1ns / 1ps
`default_nettype none

package bmff_pkg;

    localparam int BYTE_W        = 8;
    localparam int WORD_W        = 32;
    localparam int BOX_IDX_W     = 7;
    localparam int HBC_W         = 4;
    localparam int HLEN_W        = 5;
    localparam int PADDR_W       = 2;
    localparam int RES_FIFO_DEPTH = 4;

    localparam logic [PADDR_W-1:0] ADDR_STREAM_LENGTH = 2'd0;
    localparam logic [WORD_W-1:0]  STREAM_LEN_RESET   = 32'd1;

    localparam logic KIND_BOX = 1'b0;
    localparam logic KIND_END = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_TRUNCATED = 1'b1;

    localparam logic [HLEN_W-1:0] HDR_LEN_STD = 5'd8;
    localparam logic [HLEN_W-1:0] HDR_LEN_EXT = 5'd16;

    localparam logic [HBC_W-1:0] HBC_TYPE_FIRST = 4'd4;
    localparam logic [HBC_W-1:0] HBC_TYPE_LAST  = 4'd7;
    localparam logic [HBC_W-1:0] HBC_STD_DONE   = 4'd8;
    localparam logic [HBC_W-1:0] HBC_EXT_DONE   = 4'd0;

    localparam logic [WORD_W-1:0] SIZE_EXTENDED = 32'd1;
    localparam logic [WORD_W-1:0] SIZE_TO_END   = 32'd0;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_STOP   = 2'd2
    } t_phase;

    typedef struct packed {
        logic                 kind;
        logic [BOX_IDX_W-1:0] box_index;
        logic [WORD_W-1:0]    box_type;
        logic [WORD_W-1:0]    box_len;
        logic                 status;
        logic                 last_result;
    } t_res;

    typedef struct packed {
        logic rec_vld;
        logic sts_vld;
        t_res rec;
        t_res sts;
    } t_push;

endpackage

`default_nettype wire

FILE: hw/rtl/bmff_byte_if.sv
// Byte input channel of the box scanner.
`timescale 1ns / 1ps
`default_nettype none

interface bmff_byte_if import bmff_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bmff_rec_if.sv
// Result channel of the box scanner.
`timescale 1ns / 1ps
`default_nettype none

interface bmff_rec_if import bmff_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [BOX_IDX_W-1:0] box_index;
    logic [WORD_W-1:0]    box_type;
    logic [WORD_W-1:0]    box_len;
    logic                 status;
    logic                 last_result;

    modport source (output valid, output kind, output box_index, output box_type,
                    output box_len, output status, output last_result, input ready);
    modport sink   (input valid, input kind, input box_index, input box_type,
                    input box_len, input status, input last_result, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bmff_parse.sv
// Box header parser: per-byte state update and result generation.
`timescale 1ns / 1ps
`default_nettype none

module bmff_parse import bmff_pkg::*; #(
    parameter int MAX_BOXES = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_acc,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic [WORD_W-1:0] i_stream_len,
    output t_push                  o_push
);

    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    t_phase              r_phase,     n_phase;
    logic [WORD_W-1:0]   r_byte_pos,  n_byte_pos;
    logic [HBC_W-1:0]    r_hbc,       n_hbc;
    logic [2*WORD_W-1:0] r_size_sh,   n_size_sh;
    logic [WORD_W-1:0]   r_type_sh,   n_type_sh;
    logic [WORD_W-1:0]   r_body_rem,  n_body_rem;
    logic [CNT_W-1:0]    r_box_count, n_box_count;
    logic                r_err,       n_err;
    logic [WORD_W-1:0]   r_hstart,    n_hstart;

    logic                w_last;
    logic [WORD_W-1:0]   w_hs;
    logic [WORD_W-1:0]   w_rem;
    logic [2*WORD_W-1:0] w_size_base;
    logic [WORD_W-1:0]   w_type_base;
    logic [HBC_W-1:0]    w_hbc_inc;
    logic                w_check;
    logic [2*WORD_W-1:0] w_sz;
    logic [HLEN_W-1:0]   w_hlen;
    logic [WORD_W-1:0]   w_body;

    assign w_last = ({1'b0, r_byte_pos} + 33'd1) >= {1'b0, i_stream_len};
    assign w_hs   = (r_hbc == '0) ? r_byte_pos : r_hstart;
    assign w_rem  = (i_stream_len > w_hs) ? (i_stream_len - w_hs) : '0;

    always_comb begin
        n_phase     = r_phase;
        n_byte_pos  = r_byte_pos;
        n_hbc       = r_hbc;
        n_size_sh   = r_size_sh;
        n_type_sh   = r_type_sh;
        n_body_rem  = r_body_rem;
        n_box_count = r_box_count;
        n_err       = r_err;
        n_hstart    = r_hstart;
        w_size_base = (r_hbc == '0) ? '0 : r_size_sh;
        w_type_base = (r_hbc == '0) ? '0 : r_type_sh;
        w_hbc_inc   = r_hbc + HBC_W'(1);
        w_check     = 1'b0;
        w_sz        = '0;
        w_hlen      = '0;
        w_body      = '0;
        o_push      = '0;

        if (i_acc) begin
            case (r_phase)
                PH_HEADER: begin
                    n_hstart = w_hs;
                    if (r_hbc == '0 &&
                        (r_box_count >= CNT_W'(MAX_BOXES) || w_rem < WORD_W'(HDR_LEN_STD))) begin
                        n_phase = PH_STOP;
                    end else begin
                        if (r_hbc inside {[HBC_TYPE_FIRST:HBC_TYPE_LAST]}) begin
                            n_type_sh = {w_type_base[WORD_W-BYTE_W-1:0], i_data_byte};
                            n_size_sh = w_size_base;
                        end else begin
                            n_size_sh = {w_size_base[2*WORD_W-BYTE_W-1:0], i_data_byte};
                            n_type_sh = w_type_base;
                        end
                        n_hbc = w_hbc_inc;
                        if (w_hbc_inc == HBC_STD_DONE) begin
                            if (n_size_sh[WORD_W-1:0] == SIZE_EXTENDED) begin
                                if (w_rem < WORD_W'(HDR_LEN_EXT)) begin
                                    n_err   = 1'b1;
                                    n_phase = PH_STOP;
                                end
                            end else begin
                                w_hlen  = HDR_LEN_STD;
                                w_sz    = (n_size_sh[WORD_W-1:0] == SIZE_TO_END) ?
                                          {{WORD_W{1'b0}}, w_rem} :
                                          {{WORD_W{1'b0}}, n_size_sh[WORD_W-1:0]};
                                w_check = 1'b1;
                            end
                        end else if (w_hbc_inc == HBC_EXT_DONE) begin
                            w_hlen  = HDR_LEN_EXT;
                            w_sz    = n_size_sh;
                            w_check = 1'b1;
                        end
                        if (w_check) begin
                            if (w_sz < (2*WORD_W)'(w_hlen) ||
                                w_sz > {{WORD_W{1'b0}}, w_rem}) begin
                                n_err   = 1'b1;
                                n_phase = PH_STOP;
                            end else begin
                                o_push.rec_vld          = 1'b1;
                                o_push.rec.kind         = KIND_BOX;
                                o_push.rec.box_index    = BOX_IDX_W'(r_box_count);
                                o_push.rec.box_type     = n_type_sh;
                                o_push.rec.box_len      = w_sz[WORD_W-1:0];
                                o_push.rec.status       = STATUS_OK;
                                o_push.rec.last_result  = !w_last;
                                n_box_count = r_box_count + CNT_W'(1);
                                w_body      = w_sz[WORD_W-1:0] - WORD_W'(w_hlen);
                                n_body_rem  = w_body;
                                n_hbc       = '0;
                                n_phase     = (w_body != '0) ? PH_BODY : PH_HEADER;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    if (r_body_rem != '0) begin
                        n_body_rem = r_body_rem - WORD_W'(1);
                    end
                    if (n_body_rem == '0) begin
                        n_phase = PH_HEADER;
                    end
                end
                default: begin
                end
            endcase

            n_byte_pos = r_byte_pos + WORD_W'(1);

            if (w_last) begin
                o_push.sts_vld          = 1'b1;
                o_push.sts.kind         = KIND_END;
                o_push.sts.box_index    = BOX_IDX_W'(n_box_count);
                o_push.sts.box_type     = '0;
                o_push.sts.box_len      = '0;
                o_push.sts.status       = n_err ? STATUS_TRUNCATED : STATUS_OK;
                o_push.sts.last_result  = 1'b1;
                n_phase     = PH_HEADER;
                n_byte_pos  = '0;
                n_hbc       = '0;
                n_size_sh   = '0;
                n_type_sh   = '0;
                n_body_rem  = '0;
                n_box_count = '0;
                n_err       = 1'b0;
                n_hstart    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_byte_pos  <= '0;
            r_hbc       <= '0;
            r_size_sh   <= '0;
            r_type_sh   <= '0;
            r_body_rem  <= '0;
            r_box_count <= '0;
            r_err       <= 1'b0;
            r_hstart    <= '0;
        end else begin
            r_phase     <= n_phase;
            r_byte_pos  <= n_byte_pos;
            r_hbc       <= n_hbc;
            r_size_sh   <= n_size_sh;
            r_type_sh   <= n_type_sh;
            r_body_rem  <= n_body_rem;
            r_box_count <= n_box_count;
            r_err       <= n_err;
            r_hstart    <= n_hstart;
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && w_last |=> (r_byte_pos == '0) && (r_box_count == '0) && !r_err)
        else $error("state not cleared after last byte");

    a_pos_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && !w_last |=> r_byte_pos == $past(r_byte_pos) + WORD_W'(1))
        else $error("byte position did not advance");

    a_body_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY |-> r_body_rem != '0)
        else $error("body phase with nothing left to skip");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_box_count <= CNT_W'(MAX_BOXES))
        else $error("box count beyond limit");

endmodule

`default_nettype wire

FILE: hw/rtl/bmff_res_fifo.sv
// Result queue: takes up to two results per cycle, releases one per transfer.
`timescale 1ns / 1ps
`default_nettype none

module bmff_res_fifo import bmff_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    input  wire logic  i_pop,
    output logic       o_space,
    output logic       o_valid,
    output t_res       o_head
);

    localparam int PTR_W = $clog2(RES_FIFO_DEPTH);
    localparam int CNT_W = $clog2(RES_FIFO_DEPTH + 1);

    t_res             r_mem [RES_FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp,  n_wp;
    logic [PTR_W-1:0] r_rp,  n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [CNT_W-1:0] w_n_push;
    logic             w_pop;
    logic [PTR_W-1:0] w_wp1;

    assign w_n_push = CNT_W'(i_push.rec_vld) + CNT_W'(i_push.sts_vld);
    assign w_pop    = i_pop && (r_cnt != '0);
    assign w_wp1    = r_wp + PTR_W'(1);

    assign o_valid  = r_cnt != '0;
    assign o_head   = r_mem[r_rp];
    assign o_space  = r_cnt <= CNT_W'(RES_FIFO_DEPTH - 2);

    always_comb begin
        n_wp  = r_wp + PTR_W'(w_n_push);
        n_rp  = r_rp + PTR_W'(w_pop);
        n_cnt = r_cnt + w_n_push - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.rec_vld) begin
            r_mem[r_wp] <= i_push.rec;
        end
        if (i_push.sts_vld) begin
            r_mem[i_push.rec_vld ? w_wp1 : r_wp] <= i_push.sts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(RES_FIFO_DEPTH))
        else $error("result queue overflow");

endmodule

`default_nettype wire

FILE: hw/rtl/bmff_box_scanner.sv
// Top level of the box scanner: configuration register, parser and result queue.
`timescale 1ns / 1ps
`default_nettype none

// Scans the top-level boxes of an ISO base media file streamed in one byte per
// transfer; stream_length (offset 0) gives the file length and must be set
// while the block is idle. Each accepted box header yields a record with its
// ordinal, type and size; the last byte of the file yields an end status
// (ok or truncated) after any record of the same byte, and the scanner then
// starts over for the next file. A byte is taken every cycle while the queue
// has room: the parser updates its state in the cycle of the transfer and its
// results are registered in a four-entry queue. A byte that both ends a
// header and ends the file makes two results; input holds off only while the
// queue has fewer than two free entries, i.e. when the output side stalls.
module bmff_box_scanner import bmff_pkg::*; #(
    parameter int MAX_BOXES = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    bmff_byte_if.sink               i_byte,
    bmff_rec_if.source              o_rec,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [WORD_W-1:0]  pwdata,
    output logic      [WORD_W-1:0]  prdata,
    output logic                    pready
);

    logic [WORD_W-1:0] r_stream_len, n_stream_len;
    logic              w_space;
    logic              w_acc;
    logic              w_valid;
    t_push             w_push;
    t_res              w_head;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_STREAM_LENGTH) ? r_stream_len : '0;

    always_comb begin
        n_stream_len = r_stream_len;
        if (psel && penable && pwrite && paddr == ADDR_STREAM_LENGTH) begin
            n_stream_len = pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_len <= STREAM_LEN_RESET;
        end else begin
            r_stream_len <= n_stream_len;
        end
    end

    assign i_byte.ready = w_space;
    assign w_acc        = i_byte.valid && w_space;

    bmff_parse #(
        .MAX_BOXES (MAX_BOXES)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (w_acc),
        .i_data_byte (i_byte.data_byte),
        .i_stream_len(r_stream_len),
        .o_push      (w_push)
    );

    bmff_res_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_pop  (o_rec.ready),
        .o_space(w_space),
        .o_valid(w_valid),
        .o_head (w_head)
    );

    assign o_rec.valid       = w_valid;
    assign o_rec.kind        = w_head.kind;
    assign o_rec.box_index   = w_head.box_index;
    assign o_rec.box_type    = w_head.box_type;
    assign o_rec.box_len     = w_head.box_len;
    assign o_rec.status      = w_head.status;
    assign o_rec.last_result = w_head.last_result;

endmodule

`default_nettype wire
